// File: design/wvs_pkg.sv
// Shared constants, record types and helpers for the weighted value selector.
`default_nettype none
package wvs_pkg;

  localparam int MAX_VALUES = 64;
  localparam int IDX_W      = $clog2(MAX_VALUES);
  localparam int CNT_W      = $clog2(MAX_VALUES + 1);

  localparam int ID_W    = 16;
  localparam int DELTA_W = 32;
  localparam int RND_W   = 32;
  localparam int SUM_W   = 40;
  localparam int WT_W    = 40;
  localparam int TW_W    = 46;
  localparam int ACC_W   = WT_W + IDX_W;
  localparam int CMP_W   = (ACC_W > TW_W) ? ACC_W : TW_W;
  localparam int PROD_W  = 2 * RND_W;

  localparam int IN_DATA_W  = 80;
  localparam int OUT_DATA_W = 56;
  localparam int OUT_USER_W = 2;

  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = $clog2(Q_DEPTH);
  localparam int Q_CW    = $clog2(Q_DEPTH + 1);

  localparam logic [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
  localparam logic [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};
  localparam logic [TW_W-1:0]  TW_MAX  = {TW_W{1'b1}};

  // One closed candidate value as it travels from the front end to the back end.
  typedef struct packed {
    logic [RND_W-1:0] rnd;
    logic             eos;
    logic [SUM_W-1:0] sum;
    logic [ID_W-1:0]  id;
  } rec_t;

  typedef struct packed {
    logic [SUM_W-1:0] sum;
    logic [ID_W-1:0]  id;
  } entry_t;

  // The weight of a sum is its magnitude when negative, else zero.
  function automatic logic [WT_W-1:0] weight_of(input logic [SUM_W-1:0] s);
    logic [WT_W-1:0] w;
    w = s[SUM_W-1] ? WT_W'({SUM_W{1'b0}} - s) : '0;
    return w;
  endfunction

endpackage
`default_nettype wire

// File: design/wvs_front.sv
// Front end: accepts delta words, keeps the saturating running sum, emits closed values.
`default_nettype none
module wvs_front (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           s_tvalid,
  output logic                                s_tready,
  input  wire logic [wvs_pkg::IN_DATA_W-1:0]  s_tdata,
  input  wire logic                           s_tuser,
  input  wire logic                           s_tlast,
  input  wire logic                           q_full,
  output logic                                push,
  output wvs_pkg::rec_t                       push_rec
);
  import wvs_pkg::*;

  logic [SUM_W-1:0]   running;
  logic [SUM_W-1:0]   sum_next;
  logic [SUM_W:0]     wide;
  logic [ID_W-1:0]    id;
  logic [DELTA_W-1:0] delta;
  logic [RND_W-1:0]   rnd;
  logic               accept;
  logic               close;

  assign id    = s_tdata[ID_W-1:0];
  assign delta = s_tdata[ID_W +: DELTA_W];
  assign rnd   = s_tdata[ID_W + DELTA_W +: RND_W];

  assign s_tready = !q_full;
  assign accept   = s_tvalid && !q_full;
  assign close    = s_tuser || s_tlast;

  assign wide = {running[SUM_W-1], running} + {{(SUM_W + 1 - DELTA_W){delta[DELTA_W-1]}}, delta};

  always_comb begin
    if (wide[SUM_W] != wide[SUM_W-1]) begin
      sum_next = wide[SUM_W] ? SUM_MIN : SUM_MAX;
    end else begin
      sum_next = wide[SUM_W-1:0];
    end
  end

  assign push         = accept && close;
  assign push_rec.id  = id;
  assign push_rec.sum = sum_next;
  assign push_rec.eos = s_tlast;
  assign push_rec.rnd = rnd;

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= '0;
    end else if (accept) begin
      running <= close ? '0 : sum_next;
    end
  end

endmodule
`default_nettype wire

// File: design/wvs_queue.sv
// Short queue of closed values between the front end and the back end.
`default_nettype none
module wvs_queue (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  wvs_pkg::rec_t      push_rec,
  output logic               full,
  input  wire logic          pop,
  output logic               q_valid,
  output wvs_pkg::rec_t      q_rec
);
  import wvs_pkg::*;

  rec_t             slots [Q_DEPTH];
  logic [Q_AW-1:0]  wptr;
  logic [Q_AW-1:0]  rptr;
  logic [Q_CW-1:0]  fill;
  logic             do_pop;

  assign full    = (fill == Q_CW'(Q_DEPTH));
  assign q_valid = (fill != '0);
  assign q_rec   = slots[rptr];
  assign do_pop  = pop && q_valid;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wptr] <= push_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      fill <= '0;
    end else begin
      if (push) begin
        wptr <= wptr + Q_AW'(1);
      end
      if (do_pop) begin
        rptr <= rptr + Q_AW'(1);
      end
      case ({push, do_pop})
        2'b10:   fill <= fill + Q_CW'(1);
        2'b01:   fill <= fill - Q_CW'(1);
        default: fill <= fill;
      endcase
    end
  end

endmodule
`default_nettype wire

// File: design/wvs_back.sv
// Back end: stores closed values, computes the pick target, walks the store, emits the word.
`default_nettype none
module wvs_back (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            q_valid,
  input  wvs_pkg::rec_t                        q_rec,
  output logic                                 pop,
  output logic                                 m_tvalid,
  input  wire logic                            m_tready,
  output logic [wvs_pkg::OUT_DATA_W-1:0]       m_tdata,
  output logic [wvs_pkg::OUT_USER_W-1:0]       m_tuser
);
  import wvs_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_MUL_LO = 3'd1;
  localparam logic [2:0] S_MUL_HI = 3'd2;
  localparam logic [2:0] S_TGT    = 3'd3;
  localparam logic [2:0] S_WALK   = 3'd4;
  localparam logic [2:0] S_UNI    = 3'd5;
  localparam logic [2:0] S_LOAD   = 3'd6;
  localparam logic [2:0] S_EMIT   = 3'd7;

  logic [2:0]        state;
  logic [CNT_W-1:0]  count;
  logic [TW_W-1:0]   total;
  logic              overflow;
  logic              uniform;
  logic [RND_W-1:0]  rnd;
  logic [PROD_W-1:0] prod;
  logic [RND_W-1:0]  carry;
  logic [TW_W-1:0]   target;
  logic [ACC_W-1:0]  acc;
  logic [CNT_W-1:0]  issue_idx;
  logic              rd_valid;
  logic              rd_last;
  entry_t            chosen;

  entry_t            store [MAX_VALUES];
  entry_t            rd_data;
  logic [IDX_W-1:0]  rd_addr;
  logic              we;
  entry_t            wentry;

  logic [WT_W-1:0]   in_w;
  logic [TW_W:0]     tsum;
  logic              room;
  logic [RND_W-1:0]  mult_b;
  logic [PROD_W-1:0] mult_p;
  logic [ACC_W-1:0]  acc_next;
  logic              hit;
  logic              issue;

  assign pop  = (state == S_IDLE) && q_valid;
  assign room = (count < CNT_W'(MAX_VALUES));
  assign we   = pop && room;
  assign wentry.id  = q_rec.id;
  assign wentry.sum = q_rec.sum;

  assign in_w = weight_of(q_rec.sum);
  assign tsum = {1'b0, total} + (TW_W + 1)'(in_w);

  always_comb begin
    case (state)
      S_MUL_LO: mult_b = (total == '0) ? RND_W'(count) : total[RND_W-1:0];
      S_MUL_HI: mult_b = RND_W'(total[TW_W-1:RND_W]);
      default:  mult_b = '0;
    endcase
  end

  assign mult_p = rnd * mult_b;

  assign issue = (state == S_WALK) && (issue_idx < count);

  always_comb begin
    case (state)
      S_UNI:   rd_addr = prod[RND_W +: IDX_W];
      default: rd_addr = issue_idx[IDX_W-1:0];
    endcase
  end

  assign acc_next = acc + ACC_W'(weight_of(rd_data.sum));
  assign hit      = (CMP_W'(acc_next) > CMP_W'(target)) || rd_last;

  always_ff @(posedge clk) begin
    if (we) begin
      store[count[IDX_W-1:0]] <= wentry;
    end
    rd_data <= store[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      total     <= '0;
      overflow  <= 1'b0;
      rd_valid  <= 1'b0;
      m_tvalid  <= 1'b0;
    end else begin
      rd_valid <= issue;
      if (m_tvalid && m_tready && (state != S_EMIT)) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (pop) begin
            if (room) begin
              count <= count + CNT_W'(1);
              total <= tsum[TW_W] ? TW_MAX : tsum[TW_W-1:0];
            end else begin
              overflow <= 1'b1;
            end
            if (q_rec.eos) begin
              state <= S_MUL_LO;
            end
          end
        end
        S_MUL_LO: begin
          state <= (total == '0) ? S_UNI : S_MUL_HI;
        end
        S_MUL_HI: begin
          state <= S_TGT;
        end
        S_TGT: begin
          state <= S_WALK;
        end
        S_WALK: begin
          if (rd_valid && hit) begin
            state <= S_EMIT;
          end
        end
        S_UNI: begin
          state <= S_LOAD;
        end
        S_LOAD: begin
          state <= S_EMIT;
        end
        S_EMIT: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            count    <= '0;
            total    <= '0;
            overflow <= 1'b0;
            state    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (pop && q_rec.eos) begin
      rnd <= q_rec.rnd;
    end
    case (state)
      S_MUL_LO: begin
        prod    <= mult_p;
        uniform <= (total == '0);
      end
      S_MUL_HI: begin
        prod  <= mult_p;
        carry <= prod[PROD_W-1:RND_W];
      end
      S_TGT: begin
        target    <= prod[TW_W-1:0] + TW_W'(carry);
        acc       <= '0;
        issue_idx <= '0;
      end
      S_WALK: begin
        if (issue) begin
          issue_idx <= issue_idx + CNT_W'(1);
          rd_last   <= (issue_idx == count - CNT_W'(1));
        end
        if (rd_valid) begin
          acc    <= acc_next;
          chosen <= rd_data;
        end
      end
      S_LOAD: begin
        chosen <= rd_data;
      end
      S_EMIT: begin
        if (!m_tvalid || m_tready) begin
          m_tdata <= {chosen.sum, chosen.id};
          m_tuser <= {overflow, uniform};
        end
      end
      default: begin
        rd_last <= rd_last;
      end
    endcase
  end

endmodule
`default_nettype wire

// File: design/weighted_value_selector_core.sv
// Top level of the weighted value selector: front end, queue and back end.
//
// Channel  Dir  Word
// s_*      in   tdata: value_id[15:0], delta[47:16], random_word[79:48];
//               tuser: end_of_value; tlast: end_of_set
// m_*      out  tdata: chosen_value[15:0], chosen_sum[55:16];
//               tuser: picked_uniformly[0], set_overflowed[1]
//
// The front end takes one delta word per cycle while the four-entry queue has room.
// A closed value is stored by the back end while it is idle; a set end then runs the
// multiply and target states and the prefix walk over the store, or the multiply,
// uniform-read and load states for a uniform pick. The walk reads one store entry per cycle.
// Reset clears the running sum, the queue and the back-end counters; the store needs no clearing.
// A stalled output holds the back end, which then fills the queue and stalls the input.
`default_nettype none
module weighted_value_selector_core (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            s_tvalid,
  output logic                                 s_tready,
  input  wire logic [wvs_pkg::IN_DATA_W-1:0]   s_tdata,  // value_id, delta, random_word
  input  wire logic                            s_tuser,  // end_of_value
  input  wire logic                            s_tlast,
  output logic                                 m_tvalid,
  input  wire logic                            m_tready,
  output logic [wvs_pkg::OUT_DATA_W-1:0]       m_tdata,  // chosen_value, chosen_sum
  output logic [wvs_pkg::OUT_USER_W-1:0]       m_tuser   // picked_uniformly, set_overflowed
);
  import wvs_pkg::*;

  logic push;
  rec_t push_rec;
  logic q_full;
  logic pop;
  logic q_valid;
  rec_t q_rec;

  wvs_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .s_tlast  (s_tlast),
    .q_full   (q_full),
    .push     (push),
    .push_rec (push_rec)
  );

  wvs_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_rec (push_rec),
    .full     (q_full),
    .pop      (pop),
    .q_valid  (q_valid),
    .q_rec    (q_rec)
  );

  wvs_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_rec    (q_rec),
    .pop      (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

endmodule
`default_nettype wire
